// ----- rtl/core/est_pkg.sv -----
package est_pkg;

   // Input beat: one millisecond tick of encoder and button levels
   typedef struct packed {
      logic enc_a;
      logic enc_b;
      logic button_level;
   } req_type;

   // Result beat: timer status after the tick
   typedef struct packed {
      logic [6:0] count_value;
      logic       relay_on;
      logic       display_on;
      logic       running;
   } rsp_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_STEP       = 2'd1,
      CSR_COUNT_TOP  = 2'd2
   } csr_index_type;

   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] AGE_MAX            = 16'hFFFF;
   localparam logic [6:0]  TOP_LIMIT          = 7'd99;
   localparam logic [15:0] LONG_PRESS_DEFAULT = 16'd1000;
   localparam logic [15:0] STEP_DEFAULT       = 16'd1000;
   localparam logic [6:0]  COUNT_TOP_DEFAULT  = 7'd99;

endpackage

// ----- rtl/core/est_step.sv -----
module est_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [est_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          accept,
   input  est_pkg::req_type              req_data,
   output est_pkg::rsp_type              rsp_next
);
   import est_pkg::*;

   // Configuration registers
   logic [15:0] long_press_ff;
   logic [15:0] step_ticks_ff;
   logic [6:0]  count_top_ff;

   // Timer state
   logic [6:0]  count_ff,         count_in;
   logic        running_ff,       running_in;
   logic        prev_a_ff,        prev_a_in;
   logic        prev_button_ff,   prev_button_in;
   logic [15:0] press_age_ff,     press_age_in;
   logic [15:0] step_age_ff,      step_age_in;
   logic        await_release_ff, await_release_in;
   logic        display_ff,       display_in;

   logic [6:0]  eff_top;

   // Clamp the wrap point to 1..99
   always_comb begin
      if (count_top_ff == 7'd0) begin
         eff_top = 7'd1;
      end else if (count_top_ff > TOP_LIMIT) begin
         eff_top = TOP_LIMIT;
      end else begin
         eff_top = count_top_ff;
      end
   end

   // Per-tick update
   always_comb begin
      logic [15:0] sa;
      count_in         = count_ff;
      running_in       = running_ff;
      prev_a_in        = prev_a_ff;
      prev_button_in   = prev_button_ff;
      press_age_in     = press_age_ff;
      step_age_in      = step_age_ff;
      await_release_in = await_release_ff;
      display_in       = display_ff;
      sa               = '0;

      if (await_release_ff) begin
         // hold everything until the button comes up
         if (req_data.button_level) begin
            await_release_in = 1'b0;
            prev_button_in   = 1'b1;
         end
      end else if (!running_ff) begin
         // encoder steps on falling A edge
         if (req_data.enc_a != prev_a_ff) begin
            if (!req_data.enc_a) begin
               if (req_data.enc_b) begin
                  count_in = (count_ff >= eff_top) ? 7'd0 : count_ff + 7'd1;
               end else begin
                  count_in = (count_ff == 7'd0) ? eff_top : count_ff - 7'd1;
               end
               display_in = 1'b1;
            end
            prev_a_in = req_data.enc_a;
         end
         if (!req_data.button_level) begin
            if (prev_button_ff) begin
               press_age_in = '0;
            end else begin
               press_age_in = (press_age_ff == AGE_MAX) ? AGE_MAX : press_age_ff + 16'd1;
            end
            if (press_age_in >= long_press_ff) begin
               count_in         = '0;
               display_in       = 1'b1;
               await_release_in = 1'b1;
            end
         end else if (!prev_button_ff) begin
            // short press released: start
            if (press_age_ff < long_press_ff) begin
               running_in  = 1'b1;
               step_age_in = '0;
            end
         end
         prev_button_in = req_data.button_level;
      end else begin
         // countdown
         sa = (step_age_ff == AGE_MAX) ? AGE_MAX : step_age_ff + 16'd1;
         step_age_in = sa;
         if (sa >= step_ticks_ff) begin
            step_age_in = '0;
            if (count_ff <= 7'd1) begin
               running_in = 1'b0;
               display_in = 1'b0;
               count_in   = '0;
            end else begin
               count_in   = count_ff - 7'd1;
               display_in = 1'b1;
            end
         end
         if (!req_data.button_level) begin
            if (prev_button_ff) begin
               press_age_in = '0;
            end else begin
               press_age_in = (press_age_ff == AGE_MAX) ? AGE_MAX : press_age_ff + 16'd1;
            end
            if (press_age_in >= long_press_ff) begin
               running_in       = 1'b0;
               display_in       = 1'b0;
               count_in         = '0;
               await_release_in = 1'b1;
            end
         end
         prev_button_in = req_data.button_level;
      end
   end

   assign rsp_next.count_value = count_in;
   assign rsp_next.relay_on    = running_in;
   assign rsp_next.display_on  = display_in;
   assign rsp_next.running     = running_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_DEFAULT;
         step_ticks_ff <= STEP_DEFAULT;
         count_top_ff  <= COUNT_TOP_DEFAULT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_STEP:       step_ticks_ff <= csr_wdata;
            CSR_COUNT_TOP:  count_top_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // State commit on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         running_ff       <= 1'b0;
         prev_a_ff        <= 1'b1;
         prev_button_ff   <= 1'b1;
         press_age_ff     <= '0;
         step_age_ff      <= '0;
         await_release_ff <= 1'b0;
         display_ff       <= 1'b0;
      end else if (accept) begin
         count_ff         <= count_in;
         running_ff       <= running_in;
         prev_a_ff        <= prev_a_in;
         prev_button_ff   <= prev_button_in;
         press_age_ff     <= press_age_in;
         step_age_ff      <= step_age_in;
         await_release_ff <= await_release_in;
         display_ff       <= display_in;
      end
   end

endmodule

// ----- rtl/core/encoder_set_countdown_timer.sv -----
// Rotary-encoder countdown timer.
// req channel: one beat per millisecond tick with encoder A/B and button
// levels. rsp channel: exactly one beat per req beat, carrying the count,
// relay, display and running status after that tick.
// csr port: write-only; index 0 long-press ticks, 1 step ticks, 2 count top.
// Write only while the block is idle.
// Each taken req beat is registered in the output register, or in the skid
// register while the output register is stalled. Throughput: one beat per
// clock while req_stall is low; the tick update is a single pass of
// compare/increment logic between the state registers and the output
// register. Stall: an output register plus one skid register hold up to
// two results; req_stall rises when the skid register fills, which needs a
// stalled full output register; a receiver stall holds off the input until
// the skid beat has drained into the output register.
// Reset: synchronous; clears the timer (count 0, idle, display blank),
// restores registers to 1000, 1000 and 99, and empties the output stages.
module encoder_set_countdown_timer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  est_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output est_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [est_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import est_pkg::*;

   logic    accept;
   logic    out_free;
   rsp_type rsp_next;

   logic    out_valid_ff,  out_valid_in;
   rsp_type out_data_ff,   out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   est_step u_step (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .rsp_next  (rsp_next)
   );

   // Output register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = rsp_next;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
